// File: hw/rtl/chse_pkg.sv
// ----------------------------------------------------------------------------
// chse_pkg
// Shared types and constants for the chained hash set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package chse_pkg;

    localparam int MAX_BUCKETS = 1024;
    localparam int NODE_SLOTS  = 1024;
    localparam int KEY_W       = 64;
    localparam int CNT_W       = 11;
    localparam int LINK_W      = $clog2(NODE_SLOTS + 1);
    localparam int BKT_W       = $clog2(MAX_BUCKETS);
    localparam int NODE_AW     = $clog2(NODE_SLOTS);
    localparam int MAP_BITS    = 32;
    localparam int MAP_BW      = $clog2(MAP_BITS);
    localparam int MAP_WORDS   = NODE_SLOTS / MAP_BITS;
    localparam int MAP_AW      = $clog2(MAP_WORDS);

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NODE_SLOTS);

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef struct packed {
        t_op               opcode;
        logic signed [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] entry_count;
        logic             store_full;
    } t_out_word;

    typedef struct packed {
        t_op              opcode;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic sweeping;
    } t_back_status;

    // index of the lowest set bit; zero when none is set
    function automatic logic [MAP_BW-1:0] lowest_one(input logic [MAP_BITS-1:0] v);
        logic [MAP_BW-1:0] idx;
        idx = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = MAP_BW'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/chse_ram.sv
// ----------------------------------------------------------------------------
// chse_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/chse_front.sv
// ----------------------------------------------------------------------------
// chse_front
// Accepts words and computes the bucket by a bit-serial signed modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module chse_front
    import chse_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic [CNT_W-1:0] i_buckets,
    input  wire t_back_status i_status,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire t_in_word     i_in_word,
    output logic              o_push,
    output t_job              o_job,
    input  wire logic         i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate          r_state;
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_mag;
    logic             r_neg;
    logic [BKT_W-1:0] r_rem;
    logic [5:0]       r_cnt;
    logic [CNT_W-1:0] n_trial;
    logic [BKT_W-1:0] n_rem;

    assign o_in_ready = (r_state == F_IDLE) && !i_status.sweeping;

    always_comb begin
        n_trial = {r_rem, r_mag[KEY_W-1]};
        if (n_trial >= i_buckets) begin
            n_trial = n_trial - i_buckets;
        end
        n_rem = n_trial[BKT_W-1:0];
    end

    // C-style remainder takes the sign of the key; fold it back up
    always_comb begin
        o_job.opcode = r_op;
        o_job.key    = r_key;
        if (r_neg && (r_rem != '0)) begin
            o_job.bucket = BKT_W'(i_buckets - CNT_W'(r_rem));
        end else begin
            o_job.bucket = r_rem;
        end
    end

    assign o_push = (r_state == F_PUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_op  <= i_in_word.opcode;
                        r_key <= i_in_word.key;
                        r_neg <= i_in_word.key[KEY_W-1];
                        r_mag <= i_in_word.key[KEY_W-1] ? -i_in_word.key : i_in_word.key;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= (i_in_word.opcode == OP_CLEAR) ? F_PUSH : F_DIV;
                    end
                end
                F_DIV: begin
                    r_rem <= n_rem;
                    r_mag <= {r_mag[KEY_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(KEY_W - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/chse_fifo.sv
// ----------------------------------------------------------------------------
// chse_fifo
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module chse_fifo
    import chse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_head
);

    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic       n_do_push;
    logic       n_do_pop;

    assign o_full    = (r_fill == 2'd2);
    assign o_empty   = (r_fill == 2'd0);
    assign o_head    = r_ent[r_rp];
    assign n_do_push = i_push && !o_full;
    assign n_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (n_do_push) begin
            r_ent[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (n_do_push) begin
                r_wp <= !r_wp;
            end
            if (n_do_pop) begin
                r_rp <= !r_rp;
            end
            r_fill <= r_fill + {1'b0, n_do_push} - {1'b0, n_do_pop};
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/chse_back.sv
// ----------------------------------------------------------------------------
// chse_back
// Walks bucket chains in node memory, links and unlinks nodes, keeps the
// free-node bitmap and drives the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module chse_back
    import chse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_job  i_head,
    output logic       o_pop,
    output t_back_status o_status,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_word  o_out_word
);

    typedef enum logic [7:0] {
        B_SWEEP  = 8'b0000_0001,
        B_IDLE   = 8'b0000_0010,
        B_HEAD   = 8'b0000_0100,
        B_CMP    = 8'b0000_1000,
        B_DECIDE = 8'b0001_0000,
        B_ALLOC  = 8'b0010_0000,
        B_FREE   = 8'b0100_0000,
        B_DONE   = 8'b1000_0000
    } t_bstate;

    t_bstate              r_state;
    t_job                 r_job;
    logic [LINK_W-1:0]    r_cur;
    logic [LINK_W-1:0]    r_prev;
    logic [LINK_W-1:0]    r_nxt;
    logic [LINK_W-1:0]    r_headv;
    logic                 r_found;
    logic [CNT_W-1:0]     r_count;
    logic [MAP_WORDS-1:0] r_summary;   // bit set: word has a free node
    logic [BKT_W-1:0]     r_sweep_idx;
    logic                 r_emit_clear;
    logic [MAP_AW-1:0]    r_map_w;
    t_out_word            r_res;
    logic                 r_out_valid;
    t_out_word            r_out;

    // memory ports
    logic                 head_we;
    logic [BKT_W-1:0]     head_waddr, head_raddr;
    logic [LINK_W-1:0]    head_wdata, head_rdata;
    logic                 key_we;
    logic [NODE_AW-1:0]   node_waddr, node_raddr;
    logic [KEY_W-1:0]     key_rdata;
    logic                 nxt_we;
    logic [NODE_AW-1:0]   nxt_waddr;
    logic [LINK_W-1:0]    nxt_wdata, nxt_rdata;
    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr, map_raddr;
    logic [MAP_BITS-1:0]  map_wdata, map_rdata;

    logic [MAP_BW-1:0]    n_bit;
    logic [NODE_AW-1:0]   n_slot;
    logic                 n_can_emit;

    chse_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    chse_ram #(.WIDTH(KEY_W), .DEPTH(NODE_SLOTS)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(node_waddr), .i_wdata(r_job.key),
        .i_raddr(node_raddr), .o_rdata(key_rdata)
    );
    chse_ram #(.WIDTH(LINK_W), .DEPTH(NODE_SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(node_raddr), .o_rdata(nxt_rdata)
    );
    chse_ram #(.WIDTH(MAP_BITS), .DEPTH(MAP_WORDS)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rdata)
    );

    assign o_status.sweeping = (r_state == B_SWEEP);
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;
    assign n_can_emit        = !r_out_valid || i_out_ready;
    assign n_bit             = lowest_one(~map_rdata);
    assign n_slot            = {r_map_w, n_bit};

    always_comb begin
        o_pop      = 1'b0;
        head_we    = 1'b0;
        head_waddr = r_job.bucket;
        head_wdata = LINK_NONE;
        head_raddr = i_head.bucket;
        key_we     = 1'b0;
        node_waddr = n_slot;
        node_raddr = r_cur[NODE_AW-1:0];
        nxt_we     = 1'b0;
        nxt_waddr  = n_slot;
        nxt_wdata  = r_headv;
        map_we     = 1'b0;
        map_waddr  = r_sweep_idx[MAP_AW-1:0];
        map_wdata  = '0;
        map_raddr  = lowest_one(r_summary);
        unique case (r_state)
            B_SWEEP: begin
                head_we    = 1'b1;
                head_waddr = r_sweep_idx;
                map_we     = (r_sweep_idx < BKT_W'(MAP_WORDS));
            end
            B_IDLE: begin
                o_pop = !i_empty;
            end
            B_HEAD: begin
                node_raddr = head_rdata[NODE_AW-1:0];
            end
            B_CMP: begin
                node_raddr = nxt_rdata[NODE_AW-1:0];
            end
            B_DECIDE: begin
                if (r_job.opcode == OP_REMOVE && r_found) begin
                    map_raddr = r_cur[NODE_AW-1:MAP_BW];
                    if (r_prev == LINK_NONE) begin
                        head_we    = 1'b1;
                        head_wdata = r_nxt;
                    end else begin
                        nxt_we    = 1'b1;
                        nxt_waddr = r_prev[NODE_AW-1:0];
                        nxt_wdata = r_nxt;
                    end
                end
            end
            B_ALLOC: begin
                key_we     = 1'b1;
                nxt_we     = 1'b1;
                head_we    = 1'b1;
                head_wdata = {1'b0, n_slot};
                map_we     = 1'b1;
                map_waddr  = r_map_w;
                map_wdata  = map_rdata | (MAP_BITS'(1) << n_bit);
            end
            B_FREE: begin
                map_we    = 1'b1;
                map_waddr = r_cur[NODE_AW-1:MAP_BW];
                map_wdata = map_rdata & ~(MAP_BITS'(1) << r_cur[MAP_BW-1:0]);
            end
            B_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_SWEEP;
            r_sweep_idx  <= '0;
            r_emit_clear <= 1'b0;
            r_summary    <= '1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == B_DONE && n_can_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_SWEEP: begin
                    r_sweep_idx <= r_sweep_idx + BKT_W'(1);
                    if (r_sweep_idx == BKT_W'(MAX_BUCKETS - 1)) begin
                        r_summary <= '1;
                        r_count   <= '0;
                        r_res     <= '0;
                        r_state   <= r_emit_clear ? B_DONE : B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_head;
                        if (i_head.opcode == OP_CLEAR) begin
                            r_sweep_idx  <= '0;
                            r_emit_clear <= 1'b1;
                            r_state      <= B_SWEEP;
                        end else begin
                            r_state <= B_HEAD;
                        end
                    end
                end
                B_HEAD: begin
                    r_headv <= head_rdata;
                    r_prev  <= LINK_NONE;
                    r_found <= 1'b0;
                    r_cur   <= head_rdata;
                    r_state <= (head_rdata == LINK_NONE) ? B_DECIDE : B_CMP;
                end
                B_CMP: begin
                    if (key_rdata == r_job.key) begin
                        r_found <= 1'b1;
                        r_nxt   <= nxt_rdata;
                        r_state <= B_DECIDE;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= nxt_rdata;
                        if (nxt_rdata == LINK_NONE) begin
                            r_state <= B_DECIDE;
                        end
                    end
                end
                B_DECIDE: begin
                    r_res.found       <= r_found;
                    r_res.entry_count <= r_count;
                    r_res.store_full  <= (r_job.opcode == OP_INSERT) && !r_found &&
                                         (r_summary == '0);
                    if (r_job.opcode == OP_INSERT && !r_found && (r_summary != '0)) begin
                        r_map_w <= lowest_one(r_summary);
                        r_state <= B_ALLOC;
                    end else if (r_job.opcode == OP_REMOVE && r_found) begin
                        r_state <= B_FREE;
                    end else begin
                        r_state <= B_DONE;
                    end
                end
                B_ALLOC: begin
                    r_summary[r_map_w] <= ~&(map_rdata | (MAP_BITS'(1) << n_bit));
                    r_count            <= r_count + CNT_W'(1);
                    r_res.entry_count  <= r_count + CNT_W'(1);
                    r_state            <= B_DONE;
                end
                B_FREE: begin
                    r_summary[r_cur[NODE_AW-1:MAP_BW]] <= 1'b1;
                    r_count           <= r_count - CNT_W'(1);
                    r_res.entry_count <= r_count - CNT_W'(1);
                    r_state           <= B_DONE;
                end
                B_DONE: begin
                    if (n_can_emit) begin
                        r_out        <= r_res;
                        r_emit_clear <= 1'b0;
                        r_state      <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/chained_hash_set_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_set_engine
// Set of signed 64-bit keys kept by separate chaining in a node store.
// ----------------------------------------------------------------------------
// The front takes one word at a time and runs a bit-serial signed modulo
// by the bucket count on it (clear skips it), then a two-entry queue
// hands it to the back, which reads the bucket head and walks the chain
// at one node per cycle over the node memories, then links or unlinks a
// node as the operation needs and returns the result. After reset, and
// for every clear, the back sweeps all 1024 bucket heads, one per cycle,
// while no word is taken. Write the bucket count only while idle, and only before a clear.
`default_nettype none

module chained_hash_set_engine
    import chse_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_word
);

    logic [CNT_W-1:0] r_buckets;
    logic [CNT_W-1:0] n_eff;
    t_back_status     status;
    logic             push, full, pop, empty;
    t_job             job_in, job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buckets <= CNT_W'(10);
        end else if (i_cfg_we) begin
            r_buckets <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_buckets == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_buckets > CNT_W'(MAX_BUCKETS)) begin
            n_eff = CNT_W'(MAX_BUCKETS);
        end else begin
            n_eff = r_buckets;
        end
    end

    chse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_buckets(n_eff), .i_status(status),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_push(push), .o_job(job_in), .i_full(full)
    );

    chse_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job_in), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_head(job_head)
    );

    chse_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_head(job_head),
        .o_pop(pop), .o_status(status), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_out_word(o_out_word)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.entry_count <= CNT_W'(NODE_SLOTS)))
        else $error("entry count above node store size");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.store_full) |->
        (o_out_word.entry_count == CNT_W'(NODE_SLOTS) && !o_out_word.found))
        else $error("store_full with free nodes or on a hit");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.sweeping |-> !o_in_ready)
        else $error("word taken during bucket sweep");

endmodule

`default_nettype wire
